// ===== rtl/core/qvr_pkg.sv =====
// shared constant for the quaternion vector rotate block
package qvr_pkg;

	// quotient bits resolved per divider pipeline stage
	localparam int DIV_STEP = 2;

endpackage

// ===== rtl/core/qvr_item_if.sv =====
// input channel: vector and quaternion beat
interface qvr_item_if #(
	parameter int VEC_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [VEC_WIDTH-1:0]  vec_x;
	logic signed [VEC_WIDTH-1:0]  vec_y;
	logic signed [VEC_WIDTH-1:0]  vec_z;
	logic signed [QUAT_WIDTH-1:0] quat_s;
	logic signed [QUAT_WIDTH-1:0] quat_x;
	logic signed [QUAT_WIDTH-1:0] quat_y;
	logic signed [QUAT_WIDTH-1:0] quat_z;

	modport source (
		output valid, vec_x, vec_y, vec_z, quat_s, quat_x, quat_y, quat_z,
		input  ready
	);
	modport sink (
		input  valid, vec_x, vec_y, vec_z, quat_s, quat_x, quat_y, quat_z,
		output ready
	);
endinterface

// ===== rtl/core/qvr_result_if.sv =====
// output channel: rotated vector beat with status flags
interface qvr_result_if #(
	parameter int VEC_WIDTH = 32
);
	logic                        valid;
	logic                        ready;
	logic signed [VEC_WIDTH-1:0] rot_x;
	logic signed [VEC_WIDTH-1:0] rot_y;
	logic signed [VEC_WIDTH-1:0] rot_z;
	logic                        zero_quat;
	logic                        saturated;

	modport source (
		output valid, rot_x, rot_y, rot_z, zero_quat, saturated,
		input  ready
	);
	modport sink (
		input  valid, rot_x, rot_y, rot_z, zero_quat, saturated,
		output ready
	);
endinterface

// ===== rtl/core/qvr_matrix.sv =====
// rotation matrix and norm from the quaternion, two pipeline stages
module qvr_matrix #(
	parameter int VEC_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16,
	localparam int MW = 2*QUAT_WIDTH+2,
	localparam int NW = 2*QUAT_WIDTH+1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic signed [VEC_WIDTH-1:0]  vec_in [3],
	input  logic signed [QUAT_WIDTH-1:0] quat_s,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	output logic                         valid_out,
	output logic signed [VEC_WIDTH-1:0]  vec_out [3],
	output logic signed [MW-1:0]         m_out [3][3],
	output logic [NW-1:0]                n_out,
	output logic                         zero_out
);
	localparam int PW = 2*QUAT_WIDTH;

	logic                        valid_s1, valid_s2;
	logic signed [VEC_WIDTH-1:0] vec_s1 [3];
	logic signed [VEC_WIDTH-1:0] vec_s2 [3];
	logic signed [PW-1:0]        ss_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0]        xy_s1, sz_s1, xz_s1, sy_s1, yz_s1, sx_s1;
	logic signed [MW-1:0]        m_s2 [3][3];
	logic [NW-1:0]               n_s2;
	logic                        zero_s2;
	logic [NW-1:0]               n_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: quaternion products
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_in;
			ss_s1  <= PW'(quat_s) * PW'(quat_s);
			xx_s1  <= PW'(quat_x) * PW'(quat_x);
			yy_s1  <= PW'(quat_y) * PW'(quat_y);
			zz_s1  <= PW'(quat_z) * PW'(quat_z);
			xy_s1  <= PW'(quat_x) * PW'(quat_y);
			sz_s1  <= PW'(quat_s) * PW'(quat_z);
			xz_s1  <= PW'(quat_x) * PW'(quat_z);
			sy_s1  <= PW'(quat_s) * PW'(quat_y);
			yz_s1  <= PW'(quat_y) * PW'(quat_z);
			sx_s1  <= PW'(quat_s) * PW'(quat_x);
		end
	end

	assign n_c = NW'($unsigned(ss_s1)) + NW'($unsigned(xx_s1))
		+ NW'($unsigned(yy_s1)) + NW'($unsigned(zz_s1));

	// stage 2: matrix entries and norm
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2     <= vec_s1;
			n_s2       <= n_c;
			zero_s2    <= (n_c == '0);
			m_s2[0][0] <= MW'(ss_s1) + MW'(xx_s1) - MW'(yy_s1) - MW'(zz_s1);
			m_s2[0][1] <= (MW'(xy_s1) - MW'(sz_s1)) <<< 1;
			m_s2[0][2] <= (MW'(xz_s1) + MW'(sy_s1)) <<< 1;
			m_s2[1][0] <= (MW'(xy_s1) + MW'(sz_s1)) <<< 1;
			m_s2[1][1] <= MW'(ss_s1) - MW'(xx_s1) + MW'(yy_s1) - MW'(zz_s1);
			m_s2[1][2] <= (MW'(yz_s1) - MW'(sx_s1)) <<< 1;
			m_s2[2][0] <= (MW'(xz_s1) - MW'(sy_s1)) <<< 1;
			m_s2[2][1] <= (MW'(yz_s1) + MW'(sx_s1)) <<< 1;
			m_s2[2][2] <= MW'(ss_s1) - MW'(xx_s1) - MW'(yy_s1) + MW'(zz_s1);
		end
	end

	assign valid_out = valid_s2;
	assign vec_out   = vec_s2;
	assign m_out     = m_s2;
	assign n_out     = n_s2;
	assign zero_out  = zero_s2;
endmodule

// ===== rtl/core/qvr_product.sv =====
// matrix times vector, row sums and magnitudes, three pipeline stages
module qvr_product #(
	parameter int VEC_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16,
	localparam int MW = 2*QUAT_WIDTH+2,
	localparam int NW = 2*QUAT_WIDTH+1,
	localparam int PW = MW+VEC_WIDTH+2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  logic signed [VEC_WIDTH-1:0] vec_in [3],
	input  logic signed [MW-1:0]        m_in [3][3],
	input  logic [NW-1:0]               n_in,
	input  logic                        zero_in,
	output logic                        valid_out,
	output logic [PW-1:0]               mag_out [3],
	output logic                        neg_out [3],
	output logic [NW-1:0]               n_out,
	output logic                        zero_out
);
	localparam int XW = MW+VEC_WIDTH;

	logic                 valid_s3, valid_s4, valid_s5;
	logic [NW-1:0]        n_s3, n_s4, n_s5;
	logic                 zero_s3, zero_s4, zero_s5;
	logic signed [XW-1:0] p_s3 [3][3];
	logic signed [PW-1:0] acc_s4 [3];
	logic [PW-1:0]        mag_s5 [3];
	logic                 neg_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= n_in;
			n_s4    <= n_s3;
			n_s5    <= n_s4;
			zero_s3 <= zero_in;
			zero_s4 <= zero_s3;
			zero_s5 <= zero_s4;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					p_s3[r][c] <= XW'(m_in[r][c]) * XW'(vec_in[c]);
				end
				acc_s4[r] <= PW'(p_s3[r][0]) + PW'(p_s3[r][1]) + PW'(p_s3[r][2]);
				neg_s5[r] <= acc_s4[r][PW-1];
				mag_s5[r] <= acc_s4[r][PW-1] ? PW'(-acc_s4[r]) : PW'(acc_s4[r]);
			end
		end
	end

	assign valid_out = valid_s5;
	assign mag_out   = mag_s5;
	assign neg_out   = neg_s5;
	assign n_out     = n_s5;
	assign zero_out  = zero_s5;
endmodule

// ===== rtl/core/qvr_divider.sv =====
// pipelined restoring divider for the three row sums
module qvr_divider #(
	parameter int VEC_WIDTH = 32,
	parameter int NW        = 33,
	parameter int PW        = 68,
	localparam int QB = VEC_WIDTH+1,
	localparam int NS = (QB+qvr_pkg::DIV_STEP-1)/qvr_pkg::DIV_STEP,
	localparam int QP = NS*qvr_pkg::DIV_STEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  logic [PW-1:0] mag_in [3],
	input  logic          neg_in [3],
	input  logic [NW-1:0] n_in,
	input  logic          zero_in,
	output logic          valid_out,
	output logic [QP-1:0] quo_out [3],
	output logic          neg_out [3],
	output logic          zero_out
);
	logic [NW-1:0] rem_sk  [NS+1][3];
	logic [QP-1:0] wrk_sk  [NS+1][3];
	logic          neg_sk  [NS+1][3];
	logic          ovf_sk  [NS+1][3];
	logic [NW-1:0] den_sk  [NS+1];
	logic          zero_sk [NS+1];
	logic          valid_sk[NS+1];

	// upper part of the dividend is below the divisor, low part shifts in
	// otherwise the quotient does not fit and the row is flagged
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			ovf_sk[0][r] = (mag_in[r] >> QP) >= PW'(n_in);
			rem_sk[0][r] = NW'(mag_in[r] >> QP);
			wrk_sk[0][r] = QP'(mag_in[r]);
			neg_sk[0][r] = neg_in[r];
		end
		den_sk[0]   = n_in;
		zero_sk[0]  = zero_in;
		valid_sk[0] = valid_in;
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [NW-1:0] rem_nx [3];
		logic [QP-1:0] wrk_nx [3];

		always_comb begin
			logic [NW:0]   t;
			logic [NW-1:0] rv;
			logic [QP-1:0] wv;
			for (int r = 0; r < 3; r++) begin
				rv = rem_sk[k][r];
				wv = wrk_sk[k][r];
				for (int j = 0; j < qvr_pkg::DIV_STEP; j++) begin
					t  = {rv, wv[QP-1]};
					wv = wv << 1;
					if (t >= {1'b0, den_sk[k]}) begin
						rv    = NW'(t - {1'b0, den_sk[k]});
						wv[0] = 1'b1;
					end else begin
						rv = t[NW-1:0];
					end
				end
				rem_nx[r] = rv;
				wrk_nx[r] = wv;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				valid_sk[k+1] <= valid_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1]  <= rem_nx;
				wrk_sk[k+1]  <= wrk_nx;
				neg_sk[k+1]  <= neg_sk[k];
				ovf_sk[k+1]  <= ovf_sk[k];
				den_sk[k+1]  <= den_sk[k];
				zero_sk[k+1] <= zero_sk[k];
			end
		end
	end

	// oversized quotient reads as all ones so it clips downstream
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			quo_out[r] = ovf_sk[NS][r] ? '1 : wrk_sk[NS][r];
		end
	end

	assign valid_out = valid_sk[NS];
	assign neg_out   = neg_sk[NS];
	assign zero_out  = zero_sk[NS];
endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// quaternion vector rotate: rotates a vector by a non-normalized quaternion
//
// item channel (sink): one beat carries vec_x/y/z and quat_s/x/y/z.
// result channel (source): one beat per item with rot_x/y/z, zero_quat
// and saturated, in item order.
// the result is the vector part of q*(0,v)*conj(q) divided by |q|^2,
// worked exactly, truncated toward zero and clipped to the vector width.
// an all-zero quaternion gives zero components with zero_quat set.
// from item beat to result valid, a beat passes two matrix stages, three
// product and sum stages, one divider stage per two quotient bits and one
// output register.
// throughput: one beat per cycle unless the receiver stalls; the divider resolves two quotient bits
// per stage, so the pipeline depth grows with VEC_WIDTH.
// when the receiver stalls with a result held, the whole pipeline freezes
// and item.ready drops; nothing is lost or repeated.
// reset clears all valid bits; no results are pending afterward.
module quaternion_vector_rotate #(
	parameter int VEC_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	qvr_item_if.sink     item,
	qvr_result_if.source result
);
	localparam int MW = 2*QUAT_WIDTH+2;
	localparam int NW = 2*QUAT_WIDTH+1;
	localparam int PW = MW+VEC_WIDTH+2;
	localparam int QB = VEC_WIDTH+1;
	localparam int NS = (QB+qvr_pkg::DIV_STEP-1)/qvr_pkg::DIV_STEP;
	localparam int QP = NS*qvr_pkg::DIV_STEP;
	localparam logic [QP-1:0]        LIM    = QP'(1) << (VEC_WIDTH-1);
	localparam logic [VEC_WIDTH-1:0] MAXVAL = {1'b0, {(VEC_WIDTH-1){1'b1}}};
	localparam logic [VEC_WIDTH-1:0] MINVAL = {1'b1, {(VEC_WIDTH-1){1'b0}}};

	logic                        en;
	logic signed [VEC_WIDTH-1:0] vec_in [3];

	logic                        mx_valid;
	logic signed [VEC_WIDTH-1:0] mx_vec [3];
	logic signed [MW-1:0]        mx_m [3][3];
	logic [NW-1:0]               mx_n;
	logic                        mx_zero;

	logic                        pr_valid;
	logic [PW-1:0]               pr_mag [3];
	logic                        pr_neg [3];
	logic [NW-1:0]               pr_n;
	logic                        pr_zero;

	logic                        dv_valid;
	logic [QP-1:0]               dv_quo [3];
	logic                        dv_neg [3];
	logic                        dv_zero;

	logic [VEC_WIDTH-1:0]        rot_c [3];
	logic                        sat_c;

	logic                        valid_q;
	logic [VEC_WIDTH-1:0]        rot_q [3];
	logic                        zero_q;
	logic                        sat_q;

	assign en         = !valid_q || result.ready;
	assign item.ready = en;
	assign vec_in[0]  = item.vec_x;
	assign vec_in[1]  = item.vec_y;
	assign vec_in[2]  = item.vec_z;

	qvr_matrix #(.VEC_WIDTH(VEC_WIDTH), .QUAT_WIDTH(QUAT_WIDTH)) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (item.valid),
		.vec_in   (vec_in),
		.quat_s   (item.quat_s),
		.quat_x   (item.quat_x),
		.quat_y   (item.quat_y),
		.quat_z   (item.quat_z),
		.valid_out(mx_valid),
		.vec_out  (mx_vec),
		.m_out    (mx_m),
		.n_out    (mx_n),
		.zero_out (mx_zero)
	);

	qvr_product #(.VEC_WIDTH(VEC_WIDTH), .QUAT_WIDTH(QUAT_WIDTH)) u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (mx_valid),
		.vec_in   (mx_vec),
		.m_in     (mx_m),
		.n_in     (mx_n),
		.zero_in  (mx_zero),
		.valid_out(pr_valid),
		.mag_out  (pr_mag),
		.neg_out  (pr_neg),
		.n_out    (pr_n),
		.zero_out (pr_zero)
	);

	qvr_divider #(.VEC_WIDTH(VEC_WIDTH), .NW(NW), .PW(PW)) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (pr_valid),
		.mag_in   (pr_mag),
		.neg_in   (pr_neg),
		.n_in     (pr_n),
		.zero_in  (pr_zero),
		.valid_out(dv_valid),
		.quo_out  (dv_quo),
		.neg_out  (dv_neg),
		.zero_out (dv_zero)
	);

	// sign restore and clipping; a zero quaternion forces zero components
	always_comb begin
		sat_c = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (dv_zero) begin
				rot_c[r] = '0;
			end else if (dv_neg[r]) begin
				if (dv_quo[r] > LIM) begin
					rot_c[r] = MINVAL;
					sat_c    = 1'b1;
				end else begin
					rot_c[r] = VEC_WIDTH'(-dv_quo[r]);
				end
			end else begin
				if (dv_quo[r] > LIM - QP'(1)) begin
					rot_c[r] = MAXVAL;
					sat_c    = 1'b1;
				end else begin
					rot_c[r] = VEC_WIDTH'(dv_quo[r]);
				end
			end
		end
		if (dv_zero) begin
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q  <= rot_c;
			zero_q <= dv_zero;
			sat_q  <= sat_c;
		end
	end

	assign result.valid     = valid_q;
	assign result.rot_x     = rot_q[0];
	assign result.rot_y     = rot_q[1];
	assign result.rot_z     = rot_q[2];
	assign result.zero_quat = zero_q;
	assign result.saturated = sat_q;

`ifndef ASSERT_OFF
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.zero_quat |->
			result.rot_x == '0 && result.rot_y == '0 && result.rot_z == '0
			&& !result.saturated)
		else $error("zero quaternion beat with nonzero payload");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
			result.rot_x == MAXVAL || result.rot_x == MINVAL ||
			result.rot_y == MAXVAL || result.rot_y == MINVAL ||
			result.rot_z == MAXVAL || result.rot_z == MINVAL)
		else $error("saturated flag without a clipped component");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !item.ready)
		else $error("item taken while result is stalled");
`endif
endmodule

// ===== tb/quaternion_vector_rotate_tb.sv =====
// testbench for the quaternion vector rotate block: exact rotation prediction and stall checks
module quaternion_vector_rotate_tb;

	localparam int VW = 32;
	localparam int QW = 16;
	localparam int LATENCY = 6 + (VW + 2) / 2;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 zq;
		logic                 sat;
	} rot_t;

	logic clk;
	logic arst_n;
	qvr_item_if #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) item ();
	qvr_result_if #(.VEC_WIDTH(VW)) result ();

	quaternion_vector_rotate #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source)
	);

	rot_t expected_rot[$];
	int errors;
	int sent;
	int received;
	int zero_count;
	int sat_count;
	longint cycles;
	bit stall_enable;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// divide an exact sum by the norm, truncate toward zero, clip
	function automatic logic signed [VW-1:0] quot_clip(input logic signed [127:0] num,
			input logic signed [127:0] nrm, inout logic sat);
		logic signed [127:0] q;
		logic signed [127:0] maxv;
		logic signed [127:0] minv;
		begin
			q = num / nrm;
			maxv = (128'sd1 <<< (VW - 1)) - 1;
			minv = -(128'sd1 <<< (VW - 1));
			if (q > maxv) begin
				sat = 1'b1;
				quot_clip = maxv[VW-1:0];
			end else if (q < minv) begin
				sat = 1'b1;
				quot_clip = minv[VW-1:0];
			end else begin
				quot_clip = q[VW-1:0];
			end
		end
	endfunction

	function automatic rot_t rotate_vec(input logic signed [VW-1:0] vx, vy, vz,
			input logic signed [QW-1:0] qs, qx, qy, qz);
		rot_t r;
		logic signed [127:0] s, x, y, z, nrm, a, b, c;
		logic signed [127:0] m[3][3];
		logic sat;
		begin
			s = qs; x = qx; y = qy; z = qz;
			a = vx; b = vy; c = vz;
			nrm = s*s + x*x + y*y + z*z;
			sat = 1'b0;
			r.zq = 1'b0;
			if (nrm == 0) begin
				r.x = '0; r.y = '0; r.z = '0; r.zq = 1'b1;
			end else begin
				m[0][0] = s*s + x*x - y*y - z*z;
				m[0][1] = 2 * (x*y - s*z);
				m[0][2] = 2 * (x*z + s*y);
				m[1][0] = 2 * (x*y + s*z);
				m[1][1] = s*s - x*x + y*y - z*z;
				m[1][2] = 2 * (y*z - s*x);
				m[2][0] = 2 * (x*z - s*y);
				m[2][1] = 2 * (y*z + s*x);
				m[2][2] = s*s - x*x - y*y + z*z;
				r.x = quot_clip(m[0][0]*a + m[0][1]*b + m[0][2]*c, nrm, sat);
				r.y = quot_clip(m[1][0]*a + m[1][1]*b + m[1][2]*c, nrm, sat);
				r.z = quot_clip(m[2][0]*a + m[2][1]*b + m[2][2]*c, nrm, sat);
			end
			r.sat = sat;
			rotate_vec = r;
		end
	endfunction

	task automatic report(input string what, input logic [VW-1:0] got, input logic [VW-1:0] exp);
		errors++;
		$display("mismatch %s on result %0d: got %0h expected %0h", what, received, got, exp);
	endtask

	// result beat checker with random stalls on ready while stall_enable is set
	initial begin
		int wait_n;
		rot_t e;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = (stall_enable && $urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
			if (wait_n > 0) begin
				result.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			if (expected_rot.size() == 0) begin
				report("unexpected beat", result.rot_x, '0);
			end else begin
				e = expected_rot.pop_front();
				if (result.rot_x !== e.x) report("rot_x", result.rot_x, e.x);
				if (result.rot_y !== e.y) report("rot_y", result.rot_y, e.y);
				if (result.rot_z !== e.z) report("rot_z", result.rot_z, e.z);
				if (result.zero_quat !== e.zq)
					report("zero_quat", VW'(result.zero_quat), VW'(e.zq));
				if (result.saturated !== e.sat)
					report("saturated", VW'(result.saturated), VW'(e.sat));
				zero_count += int'(e.zq);
				sat_count += int'(e.sat);
			end
			received++;
		end
	end

	task automatic send_item(input logic signed [VW-1:0] vx, vy, vz,
			input logic signed [QW-1:0] qs, qx, qy, qz, input bit gaps);
		int wait_n;
		wait_n = (gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
		if (wait_n > 0) begin
			item.valid <= 1'b0;
			repeat (wait_n) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.vec_x <= vx; item.vec_y <= vy; item.vec_z <= vz;
		item.quat_s <= qs; item.quat_x <= qx; item.quat_y <= qy; item.quat_z <= qz;
		do @(posedge clk); while (!item.ready);
		expected_rot.insert(expected_rot.size(), rotate_vec(vx, vy, vz, qs, qx, qy, qz));
		sent++;
	endtask

	task automatic drain_results();
		item.valid <= 1'b0;
		while (expected_rot.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [QW-1:0] rand_q();
		case ($urandom_range(0, 4))
			0: rand_q = QW'($signed($urandom_range(0, 3)) - 1);
			1: rand_q = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: rand_q = QW'($signed($urandom_range(0, 255)) - 128);
			default: rand_q = QW'($urandom);
		endcase
	endfunction

	function automatic logic signed [VW-1:0] rand_v();
		case ($urandom_range(0, 4))
			0: rand_v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1: rand_v = VW'($signed($urandom_range(0, 2000)) - 1000);
			default: rand_v = VW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		stall_enable = 1'b0;
		send_item(32'sh10000, 32'sh20000, -32'sh30000, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_item(32'sh10000, 32'sh0, 32'sh0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b0);
		send_item(32'sh10000, 32'sh0, 32'sh0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0);
		send_item(32'sh1234, -32'sh5678, 32'sh9abc, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		send_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sd1, 16'sd1, 16'sd1,
			16'sd1, 1'b0);
		send_item(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sd1, 16'sd1, 16'sd0,
			16'sd0, 1'b0);
		send_item(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh8000, 1'b0);
		send_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 1'b0);
		send_item(-32'sd1, 32'sd1, -32'sd1, 16'sh0, 16'sh7fff, 16'sh0, 16'sh0, 1'b0);
		send_item(32'sh40000000, 32'sh40000000, 32'sh0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0);
		send_item(32'sh0, 32'sh0, 32'sh0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		send_item(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 16'shffff, 16'sh5555,
			16'shaaaa, 16'sh0001, 1'b0);
		drain_results();
	endtask

	task automatic test_random(input int count, input bit gaps);
		stall_enable = gaps;
		repeat (count) send_item(rand_v(), rand_v(), rand_v(), rand_q(), rand_q(), rand_q(),
			rand_q(), gaps);
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		errors = 0;
		stall_enable = 1'b0;
		item.valid <= 1'b0;
		item.vec_x <= '0; item.vec_y <= '0; item.vec_z <= '0;
		item.quat_s <= '0; item.quat_x <= '0; item.quat_y <= '0; item.quat_z <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 1'b0);
		drain_results();
		test_random(450, 1'b1);
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d items, checked %0d results", sent, received);
		$display("zero quaternions %0d, saturated results %0d", zero_count, sat_count);
		if (errors == 0 && expected_rot.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/qvr_pkg.sv
rtl/core/qvr_item_if.sv
rtl/core/qvr_result_if.sv
rtl/core/qvr_matrix.sv
rtl/core/qvr_product.sv
rtl/core/qvr_divider.sv
rtl/core/quaternion_vector_rotate.sv
tb/quaternion_vector_rotate_tb.sv
